[sv/fd_pkg.sv]
`timescale 1ns / 1ps
package fd_pkg;

  // default fraction bits of the reflectance
  localparam int unsigned OUT_FRAC_BITS_DEF = 16;

  // Q.14 fixed-point one and the widths of it, its square, the indices, the cosine and their product
  localparam int unsigned ONE_Q14 = 16384;
  localparam int unsigned Q14_W   = 15;
  localparam int unsigned SQ_W    = 29;
  localparam int unsigned ETA_W   = 16;
  localparam int unsigned COS_W   = 16;
  localparam int unsigned PROD_W  = ETA_W + Q14_W;

  // carried alongside the cosine and index pipeline
  typedef struct packed {
    logic [Q14_W-1:0] c;
    logic [ETA_W-1:0] eta_i;
    logic [ETA_W-1:0] eta_t;
  } fd_geom_t;

endpackage

[sv/fd_if.sv]
`timescale 1ns / 1ps
interface fd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] cos_incident;
  logic [15:0] eta_outside;
  logic [15:0] eta_inside;

  modport source (output valid, output cos_incident, output eta_outside,
                  output eta_inside, input ready);
  modport sink   (input valid, input cos_incident, input eta_outside,
                  input eta_inside, output ready);
endinterface

interface fd_out_if #(
  parameter int unsigned RW = 17
);
  logic          valid;
  logic          ready;
  logic [RW-1:0] reflectance;
  logic          total_internal;

  modport source (output valid, output reflectance, output total_internal,
                  input ready);
  modport sink   (input valid, input reflectance, input total_internal,
                  output ready);
endinterface

[sv/fresnel_dielectric.sv]
`timescale 1ns / 1ps
// Unpolarized Fresnel reflectance at a dielectric boundary. Each input word
// (signed Q2.14 cosine, Q4.12 indices) yields one result word: reflectance in
// Q1.OUT_FRAC_BITS and a total internal reflection flag. The block takes one
// word per clock while it is not held. It is built from two chains of
// square-root cells (one root bit per cell), one chain of divide cells for
// Snell's law and two parallel chains of divide cells (one quotient bit per
// cell) for the amplitude coefficients. The whole pipeline holds while a
// finished word waits at the output.
module fresnel_dielectric #(
  parameter int unsigned OUT_FRAC_BITS = fd_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  fd_in_if.sink    in_i,
  fd_out_if.source out_o
);
  import fd_pkg::*;

  localparam int unsigned F    = OUT_FRAC_BITS;
  localparam int unsigned RW   = F + 1;
  localparam int unsigned SUMW = PROD_W + 1;
  localparam int unsigned NUMW = PROD_W + F;
  localparam int unsigned GW   = $bits(fd_geom_t);

  logic en;
  logic out_valid_q;
  logic [RW-1:0] out_refl_q;
  logic          out_tir_q;

  // advance everything unless the output word is held
  assign en        = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage A: clamp, fold sign, replace zero indices by one and swap indices
  logic signed [COS_W:0] cs;
  logic [ETA_W-1:0]      eo, ei;
  fd_geom_t              a_d, a_q;
  logic                  a_valid_q;

  always_comb begin
    cs = $signed({in_i.cos_incident[COS_W-1], in_i.cos_incident});
    if (cs > $signed((COS_W + 1)'(ONE_Q14))) cs = (COS_W + 1)'(ONE_Q14);
    if (cs < -$signed((COS_W + 1)'(ONE_Q14))) cs = -$signed((COS_W + 1)'(ONE_Q14));
    eo = (in_i.eta_outside == '0) ? ETA_W'(1) : in_i.eta_outside;
    ei = (in_i.eta_inside == '0) ? ETA_W'(1) : in_i.eta_inside;
    if (cs > 0) begin
      a_d.c     = Q14_W'(cs);
      a_d.eta_i = eo;
      a_d.eta_t = ei;
    end else begin
      a_d.c     = Q14_W'(-cs);
      a_d.eta_i = ei;
      a_d.eta_t = eo;
    end
  end

  // stage B: 1 - c^2
  logic [SQ_W-1:0] b_v_q;
  fd_geom_t        b_q;
  logic            b_valid_q;

  // stage C: etaI * sinI
  logic [PROD_W-1:0] c_num_q;
  fd_geom_t          c_q;
  logic              c_valid_q;

  // sqrt of 1 - c^2
  logic             s1_valid;
  logic [Q14_W-1:0] s1_root;
  fd_geom_t         s1_side;

  fd_sqrt #(.VW(SQ_W), .RW(Q14_W), .PW(GW)) u_sqrt_sin (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(b_valid_q), .value_i(b_v_q), .side_i(b_q),
    .valid_o(s1_valid), .root_o(s1_root), .side_o(s1_side)
  );

  // Snell: sinT = etaI * sinI / etaT
  logic             d1_valid, d1_ovf;
  logic [Q14_W-1:0] d1_quo;
  fd_geom_t         d1_side;

  fd_div #(.NW(PROD_W), .DW(ETA_W), .QW(Q14_W), .PW(GW)) u_div_snell (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(c_valid_q), .num_i(c_num_q), .den_i(c_q.eta_t), .side_i(c_q),
    .valid_o(d1_valid), .quo_o(d1_quo), .ovf_o(d1_ovf), .side_o(d1_side)
  );

  // stage D: saturate sinT, flag total internal reflection, 1 - sinT^2
  logic [Q14_W-1:0] sin_t;
  logic [SQ_W-1:0]  d_v_q;
  logic [GW:0]      d_q;
  logic             d_valid_q;

  assign sin_t = (d1_ovf || d1_quo > Q14_W'(ONE_Q14)) ? Q14_W'(ONE_Q14) : d1_quo;

  // sqrt of 1 - sinT^2
  logic             s2_valid;
  logic [Q14_W-1:0] cos_t;
  logic [GW:0]      s2_side;
  fd_geom_t         s2_g;
  logic             s2_tir;

  fd_sqrt #(.VW(SQ_W), .RW(Q14_W), .PW(GW + 1)) u_sqrt_cos (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(d_valid_q), .value_i(d_v_q), .side_i(d_q),
    .valid_o(s2_valid), .root_o(cos_t), .side_o(s2_side)
  );
  assign s2_tir = s2_side[GW];
  assign s2_g   = s2_side[GW-1:0];

  // stage E: the four products
  logic [PROD_W-1:0] e_par_n_q, e_par_d_q, e_per_n_q, e_per_d_q;
  logic              e_tir_q, e_valid_q;

  // stage F: difference and sum per coefficient
  logic [NUMW-1:0] f_par_num_q, f_per_num_q;
  logic [SUMW-1:0] f_par_den_q, f_per_den_q;
  logic            f_tir_q, f_par_z_q, f_per_z_q, f_valid_q;
  logic [PROD_W-1:0] par_diff, per_diff;
  logic [SUMW-1:0]   par_sum, per_sum;

  always_comb begin
    par_diff = (e_par_n_q >= e_par_d_q) ? e_par_n_q - e_par_d_q : e_par_d_q - e_par_n_q;
    per_diff = (e_per_n_q >= e_per_d_q) ? e_per_n_q - e_per_d_q : e_per_d_q - e_per_n_q;
    par_sum  = SUMW'(e_par_n_q) + SUMW'(e_par_d_q);
    per_sum  = SUMW'(e_per_n_q) + SUMW'(e_per_d_q);
  end

  // coefficient magnitudes |n-d| / (n+d)
  logic          ga_valid;
  logic [RW-1:0] p_par, p_per;
  logic [1:0]    ga_side;
  logic          gb_side;

  fd_div #(.NW(NUMW), .DW(SUMW), .QW(RW), .PW(2)) u_div_par (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid_q), .num_i(f_par_num_q), .den_i(f_par_den_q),
    .side_i({f_tir_q, f_par_z_q}),
    .valid_o(ga_valid), .quo_o(p_par), .ovf_o(), .side_o(ga_side)
  );

  fd_div #(.NW(NUMW), .DW(SUMW), .QW(RW), .PW(1)) u_div_per (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(f_valid_q), .num_i(f_per_num_q), .den_i(f_per_den_q),
    .side_i(f_per_z_q),
    .valid_o(), .quo_o(p_per), .ovf_o(), .side_o(gb_side)
  );

  // stage G: squares
  logic [2*RW-1:0] sq_par, sq_per;
  logic [RW-1:0]   g_par_q, g_per_q;
  logic            g_tir_q, g_valid_q;

  assign sq_par = (2 * RW)'(p_par) * (2 * RW)'(p_par);
  assign sq_per = (2 * RW)'(p_per) * (2 * RW)'(p_per);

  // stage H: mean, or one on total internal reflection
  logic [RW:0] refl_sum;
  assign refl_sum = (RW + 1)'(g_par_q) + (RW + 1)'(g_per_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      e_valid_q   <= 1'b0;
      f_valid_q   <= 1'b0;
      g_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q   <= in_i.valid;
      b_valid_q   <= a_valid_q;
      c_valid_q   <= s1_valid;
      d_valid_q   <= d1_valid;
      e_valid_q   <= s2_valid;
      f_valid_q   <= e_valid_q;
      g_valid_q   <= ga_valid;
      out_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= a_d;

      b_q   <= a_q;
      b_v_q <= SQ_W'((SQ_W + 1)'(ONE_Q14 * ONE_Q14)
                     - (SQ_W + 1)'(a_q.c) * (SQ_W + 1)'(a_q.c));

      c_q     <= s1_side;
      c_num_q <= PROD_W'(s1_side.eta_i) * PROD_W'(s1_root);

      d_q   <= {sin_t == Q14_W'(ONE_Q14), d1_side};
      d_v_q <= SQ_W'((SQ_W + 1)'(ONE_Q14 * ONE_Q14)
                     - (SQ_W + 1)'(sin_t) * (SQ_W + 1)'(sin_t));

      e_tir_q   <= s2_tir;
      e_par_n_q <= PROD_W'(s2_g.eta_t) * PROD_W'(s2_g.c);
      e_par_d_q <= PROD_W'(s2_g.eta_i) * PROD_W'(cos_t);
      e_per_n_q <= PROD_W'(s2_g.eta_i) * PROD_W'(s2_g.c);
      e_per_d_q <= PROD_W'(s2_g.eta_t) * PROD_W'(cos_t);

      f_tir_q     <= e_tir_q;
      f_par_num_q <= NUMW'(par_diff) << F;
      f_per_num_q <= NUMW'(per_diff) << F;
      f_par_den_q <= par_sum;
      f_per_den_q <= per_sum;
      f_par_z_q   <= par_sum == '0;
      f_per_z_q   <= per_sum == '0;

      g_tir_q <= ga_side[1];
      g_par_q <= ga_side[0] ? '0 : RW'(sq_par >> F);
      g_per_q <= gb_side ? '0 : RW'(sq_per >> F);

      out_tir_q  <= g_tir_q;
      out_refl_q <= g_tir_q ? (RW'(1) << F) : RW'(refl_sum >> 1);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.reflectance    = out_refl_q;
  assign out_o.total_internal = out_tir_q;
endmodule

[sv/fd_sqrt_cell.sv]
`timescale 1ns / 1ps
module fd_sqrt_cell #(
  parameter int unsigned VW  = 29,
  parameter int unsigned RW  = 15,
  parameter int unsigned PW  = 1,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [VW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [VW-1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [PW-1:0] side_o
);
  localparam int unsigned CW = ((VW > 2 * RW) ? VW : 2 * RW) + 1;

  logic [CW-1:0] trial;
  logic          take;
  logic [VW-1:0] rem_d, rem_q;
  logic [RW-1:0] root_d, root_q;
  logic [PW-1:0] side_q;
  logic          valid_q;

  // try setting this root bit: (r + b)^2 - r^2 = 2rb + b^2
  always_comb begin
    trial  = (CW'(root_i) << (BIT + 1)) + (CW'(1) << (2 * BIT));
    take   = CW'(rem_i) >= trial;
    rem_d  = take ? VW'(CW'(rem_i) - trial) : rem_i;
    root_d = take ? (root_i | (RW'(1) << BIT)) : root_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;
endmodule

[sv/fd_sqrt.sv]
`timescale 1ns / 1ps
module fd_sqrt #(
  parameter int unsigned VW = 29,
  parameter int unsigned RW = 15,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [VW-1:0] value_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [RW-1:0] root_o,
  output logic [PW-1:0] side_o
);
  logic          vld  [RW+1];
  logic [VW-1:0] rem  [RW+1];
  logic [RW-1:0] root [RW+1];
  logic [PW-1:0] side [RW+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = value_i;
  assign root[0] = '0;
  assign side[0] = side_i;

  // one root bit per cell, most significant first
  for (genvar g = 0; g < RW; g++) begin : g_cell
    fd_sqrt_cell #(.VW(VW), .RW(RW), .PW(PW), .BIT(RW - 1 - g)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(vld[g]), .rem_i(rem[g]), .root_i(root[g]), .side_i(side[g]),
      .valid_o(vld[g+1]), .rem_o(rem[g+1]), .root_o(root[g+1]),
      .side_o(side[g+1])
    );
  end

  assign valid_o = vld[RW];
  assign root_o  = root[RW];
  assign side_o  = side[RW];
endmodule

[sv/fd_div_cell.sv]
`timescale 1ns / 1ps
module fd_div_cell #(
  parameter int unsigned NW  = 31,
  parameter int unsigned DW  = 16,
  parameter int unsigned QW  = 15,
  parameter int unsigned PW  = 1,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] rem_i,
  input  logic [DW-1:0] den_i,
  input  logic [QW-1:0] quo_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [NW-1:0] rem_o,
  output logic [DW-1:0] den_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] side_o
);
  localparam int unsigned CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [CW-1:0] shifted;
  logic          take;
  logic [NW-1:0] rem_d, rem_q;
  logic [QW-1:0] quo_d, quo_q;
  logic [DW-1:0] den_q;
  logic [PW-1:0] side_q;
  logic          valid_q;

  // restoring step for one quotient bit
  always_comb begin
    shifted = CW'(den_i) << BIT;
    take    = CW'(rem_i) >= shifted;
    rem_d   = take ? NW'(CW'(rem_i) - shifted) : rem_i;
    quo_d   = take ? (quo_i | (QW'(1) << BIT)) : quo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      den_q  <= den_i;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign quo_o   = quo_q;
  assign side_o  = side_q;
endmodule

[sv/fd_div.sv]
`timescale 1ns / 1ps
module fd_div #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 16,
  parameter int unsigned QW = 15,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [PW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic          ovf_o,
  output logic [PW-1:0] side_o
);
  localparam int unsigned CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic          vld  [QW+1];
  logic [NW-1:0] rem  [QW+1];
  logic [DW-1:0] den  [QW+1];
  logic [QW-1:0] quo  [QW+1];
  logic [PW:0]   side [QW+1];
  logic          valid_q;
  logic [NW-1:0] num_q;
  logic [DW-1:0] den_q;
  logic [PW-1:0] side_q;
  logic          ovf_q;

  // entry stage: flag quotients that do not fit in QW bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      side_q <= side_i;
      ovf_q  <= CW'(num_i) >= (CW'(den_i) << QW);
    end
  end

  assign vld[0]  = valid_q;
  assign rem[0]  = num_q;
  assign den[0]  = den_q;
  assign quo[0]  = '0;
  assign side[0] = {ovf_q, side_q};

  for (genvar g = 0; g < QW; g++) begin : g_cell
    fd_div_cell #(.NW(NW), .DW(DW), .QW(QW), .PW(PW + 1), .BIT(QW - 1 - g)) u_cell (
      .clk_i, .rst_ni, .en_i,
      .valid_i(vld[g]), .rem_i(rem[g]), .den_i(den[g]), .quo_i(quo[g]),
      .side_i(side[g]),
      .valid_o(vld[g+1]), .rem_o(rem[g+1]), .den_o(den[g+1]),
      .quo_o(quo[g+1]), .side_o(side[g+1])
    );
  end

  assign valid_o = vld[QW];
  assign quo_o   = quo[QW];
  assign ovf_o   = side[QW][PW];
  assign side_o  = side[QW][PW-1:0];
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import fd_pkg::*;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned LATENCY   = 56 + FRAC_BITS;
  localparam int unsigned N_RANDOM  = 500;
  localparam int unsigned MAX_CYCLES = 400000;

  typedef struct packed {
    logic [15:0] cos_incident;
    logic [15:0] eta_outside;
    logic [15:0] eta_inside;
  } ray_hit_t;

  typedef struct packed {
    logic [FRAC_BITS:0] reflectance;
    logic               total_internal;
  } fresnel_t;

  logic clk_i;
  logic rst_ni;

  fd_in_if                 in_if ();
  fd_out_if #(.RW(FRAC_BITS+1)) out_if ();

  fresnel_dielectric #(.OUT_FRAC_BITS(FRAC_BITS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  ray_hit_t hit_q[$];
  fresnel_t refl_q[$];
  int unsigned errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_tir;
  int unsigned cycles;
  int unsigned send_gap;
  int unsigned recv_gap;
  int unsigned hold_off;
  bit          hold_done;
  bit          stim_done;

  // Clock
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Bitwise integer square root, floor
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 30;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Squared amplitude ratio ((n-d)/(n+d))^2 in Q.FRAC_BITS
  function automatic longint unsigned amp_ratio_sq(input longint unsigned n,
                                                   input longint unsigned d);
    longint unsigned diff;
    longint unsigned p;
    diff = (n >= d) ? n - d : d - n;
    if (n + d == 0) return 0;
    p = (diff << FRAC_BITS) / (n + d);
    return (p * p) >> FRAC_BITS;
  endfunction

  // Expected reflectance for one ray hit
  function automatic fresnel_t fresnel_reflect(input ray_hit_t h);
    fresnel_t        r;
    int              cs;
    longint unsigned eta_i, eta_t, tmp, c, sin_i, sin_t, cos_t, rpar, rper;
    cs    = $signed(h.cos_incident);
    eta_i = (h.eta_outside == 0) ? 1 : h.eta_outside;
    eta_t = (h.eta_inside == 0) ? 1 : h.eta_inside;
    if (cs > int'(ONE_Q14)) cs = ONE_Q14;
    if (cs < -int'(ONE_Q14)) cs = -int'(ONE_Q14);
    if (cs > 0) begin
      c = cs;
    end else begin
      tmp = eta_i; eta_i = eta_t; eta_t = tmp;
      c = -cs;
    end
    sin_i = int_sqrt((64'd1 << 28) - c * c);
    sin_t = (eta_i * sin_i) / eta_t;
    if (sin_t >= ONE_Q14) begin
      r.reflectance    = 1 << FRAC_BITS;
      r.total_internal = 1'b1;
      return r;
    end
    cos_t = int_sqrt((64'd1 << 28) - sin_t * sin_t);
    rpar  = amp_ratio_sq(eta_t * c, eta_i * cos_t);
    rper  = amp_ratio_sq(eta_i * c, eta_t * cos_t);
    r.reflectance    = (rpar + rper) >> 1;
    r.total_internal = 1'b0;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  function automatic ray_hit_t rand_hit();
    ray_hit_t h;
    int unsigned sel;
    h.cos_incident = 16'($urandom());
    h.eta_outside  = 16'($urandom());
    h.eta_inside   = 16'($urandom());
    sel = $urandom_range(0, 9);
    // mostly in-range cosines with realistic indices
    if (sel < 6) begin
      h.cos_incident = 16'($urandom_range(0, 2 * ONE_Q14) - ONE_Q14);
      h.eta_outside  = 16'($urandom_range(4096, 12288));
      h.eta_inside   = 16'($urandom_range(4096, 12288));
    end else if (sel < 8) begin
      h.eta_outside  = 16'($urandom_range(1, 65535));
      h.eta_inside   = 16'($urandom_range(1, 65535));
    end
    return h;
  endfunction

  task automatic add_hit(input logic [15:0] c, input logic [15:0] eo,
                         input logic [15:0] ei);
    ray_hit_t h;
    h.cos_incident = c;
    h.eta_outside  = eo;
    h.eta_inside   = ei;
    hit_q.push_back(h);
  endtask

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    // directed: extremes, clamp, zero cosine, equal indices, TIR
    add_hit(16'h4000, 16'h1000, 16'h1800);
    add_hit(16'hC000, 16'h1000, 16'h1800);
    add_hit(16'h7FFF, 16'h1000, 16'h1800);
    add_hit(16'h8000, 16'h1800, 16'h1000);
    add_hit(16'h0000, 16'h1000, 16'h1800);
    add_hit(16'h0000, 16'h1800, 16'h1000);
    add_hit(16'h0001, 16'h1800, 16'h1000);
    add_hit(16'hFFFF, 16'h1000, 16'h1800);
    add_hit(16'h2000, 16'h1555, 16'h1555);
    add_hit(16'h1000, 16'h1800, 16'h1000);
    add_hit(16'h0800, 16'hFFFF, 16'h0001);
    add_hit(16'h3FFF, 16'h0001, 16'hFFFF);
    add_hit(16'h2D41, 16'hFFFF, 16'hFFFF);
    add_hit(16'h4000, 16'h0001, 16'h0001);
    add_hit(16'hD2BF, 16'h1000, 16'h2000);
    add_hit(16'h5555, 16'hAAAA, 16'h5555);
    add_hit(16'hAAAA, 16'h5555, 16'hAAAA);
    add_hit(16'h0100, 16'h1000, 16'h1000);
    for (int i = 0; i < N_RANDOM; i++) hit_q.push_back(rand_hit());
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.cos_incident <= '0;
      in_if.eta_outside  <= '0;
      in_if.eta_inside   <= '0;
      send_gap           <= 0;
      n_sent             <= 0;
    end else begin
      // retire the accepted word
      if (in_if.valid && in_if.ready) begin
        refl_q.push_back(fresnel_reflect({in_if.cos_incident, in_if.eta_outside,
                                          in_if.eta_inside}));
        n_sent <= n_sent + 1;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered word
      end else if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (hit_q.size() != 0) begin
        {in_if.cos_incident, in_if.eta_outside, in_if.eta_inside} <= hit_q.pop_front();
        in_if.valid <= 1'b1;
        send_gap    <= pick_gap();
      end else begin
        in_if.valid <= 1'b0;
        stim_done   <= 1'b1;
      end
    end
  end

  // Receiver ready, with one long hold-off while the sender keeps offering
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
      hold_off     <= 0;
      hold_done    <= 1'b0;
    end else if (!hold_done && n_sent >= 40) begin
      out_if.ready <= 1'b0;
      hold_off     <= hold_off + 1;
      if (hold_off >= 3 * LATENCY) hold_done <= 1'b1;
    end else if (recv_gap != 0) begin
      out_if.ready <= 1'b0;
      recv_gap     <= recv_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    fresnel_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (refl_q.size() == 0) begin
        $display("%0t: unexpected word refl=%0d tir=%0b", $time,
                 out_if.reflectance, out_if.total_internal);
        errors = errors + 1;
      end else begin
        exp_r = refl_q.pop_front();
        n_checked = n_checked + 1;
        if (exp_r.total_internal) n_tir = n_tir + 1;
        if (out_if.reflectance !== exp_r.reflectance) begin
          $display("%0t: reflectance expected %0d actual %0d", $time,
                   exp_r.reflectance, out_if.reflectance);
          errors = errors + 1;
        end
        if (out_if.total_internal !== exp_r.total_internal) begin
          $display("%0t: total_internal expected %0b actual %0b", $time,
                   exp_r.total_internal, out_if.total_internal);
          errors = errors + 1;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    cycles = 0;
    while (!(stim_done && refl_q.size() == 0) && cycles < MAX_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
    end else begin
      repeat (2 * LATENCY) @(posedge clk_i);
      $display("checked %0d words, %0d with total internal reflection,", n_checked, n_tir);
      $display("including clamped, zero and grazing cosines and a long output stall");
      if (errors == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

[filelist.f]
sv/fd_pkg.sv
sv/fd_if.sv
sv/fd_sqrt_cell.sv
sv/fd_sqrt.sv
sv/fd_div_cell.sv
sv/fd_div.sv
sv/fresnel_dielectric.sv
sim/testbench.sv
